// ===== rtl/abkf_pkg.sv =====
// shared types and constants for the angle / bias kalman filter
`timescale 1ns / 1ps
package abkf_pkg;

    localparam int COV_FRAC = 30;

    typedef enum logic [1:0] {
        REG_TIME_STEP   = 2'd0,
        REG_ANGLE_NOISE = 2'd1,
        REG_BIAS_NOISE  = 2'd2,
        REG_MEAS_NOISE  = 2'd3
    } reg_idx_t;

    // sequencer steps
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_M_RATE,
        ST_M_P11,
        ST_T_SUM,
        ST_M_T,
        ST_M_Q11,
        ST_DIV0_GO,
        ST_DIV0_WAIT,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_M_K0Y,
        ST_M_K1Y,
        ST_M_K0P00,
        ST_M_K0P01,
        ST_M_K1P00,
        ST_M_K1P01,
        ST_STORE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctrl_t;

    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        if (v > 67'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -67'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

// ===== rtl/abkf_mul.sv =====
// shared signed multiplier with rounding after the 30-bit shift
`timescale 1ns / 1ps
module abkf_mul (
    input  logic               aclk,
    input  logic signed [32:0] a,
    input  logic signed [34:0] b,
    output logic signed [66:0] p
);
    logic [32:0] mag_a;
    logic [34:0] mag_b;
    logic        neg;
    logic [67:0] prod;
    logic [37:0] rnd;
    logic signed [66:0] p_next;
    logic signed [66:0] p_reg;

    always_comb begin
        mag_a  = a[32] ? 33'(-a) : 33'(a);
        mag_b  = b[34] ? 35'(-b) : 35'(b);
        neg    = a[32] ^ b[34];
        prod   = mag_a * mag_b;
        rnd    = 38'((prod + (68'd1 << (abkf_pkg::COV_FRAC - 1))) >> abkf_pkg::COV_FRAC);
        p_next = neg ? -$signed({29'd0, rnd}) : $signed({29'd0, rnd});
    end

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

    assign p = p_reg;
endmodule

// ===== rtl/abkf_div.sv =====
// radix-2 restoring divider for the rounded gain quotient
`timescale 1ns / 1ps
module abkf_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [32:0] den,
    output logic               busy,
    output logic               done,
    output logic signed [31:0] quot
);
    // quotient of (2n + d) / (2d) with n = |num| << 30
    logic [63:0] dvd_reg, dvd_next;
    logic [34:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [34:0] dv_reg, dv_next;
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] mag_n;
    logic [32:0] mag_d;
    logic [35:0] trial;
    logic [35:0] shifted;
    logic [33:0] qsat;

    always_comb begin
        mag_n     = num[31] ? 32'(-num) : 32'(num);
        mag_d     = den[32] ? 33'(-den) : 33'(den);
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dv_next   = dv_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, dvd_reg[63]};
        trial     = shifted - {1'b0, dv_reg};
        if (start) begin
            dvd_next  = ({1'b0, mag_n, 31'd0}) + 64'(mag_d);
            dv_next   = {1'b0, mag_d, 1'b0};
            rem_next  = '0;
            q_next    = '0;
            neg_next  = num[31] ^ den[32];
            zero_next = (den == '0);
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[62:0], 1'b0};
            if (!trial[35]) begin
                rem_next = trial[34:0];
                q_next   = {q_reg[62:0], 1'b1};
            end else begin
                rem_next = shifted[34:0];
                q_next   = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        dv_reg   <= dv_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    always_comb begin
        qsat = (q_reg > 64'h1_0000_0000) ? 34'h1_0000_0000 : q_reg[33:0];
        if (zero_reg) begin
            quot = '0;
        end else begin
            quot = abkf_pkg::sat32(neg_reg ? -$signed({33'd0, qsat}) : $signed({33'd0, qsat}));
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
endmodule

// ===== rtl/angle_bias_kalman_filter_core.sv =====
// top level: per-axis two-state kalman filter with shared multiplier and divider
`timescale 1ns / 1ps
// usage:
// - input channel s_valid/s_ready carries axis, measured angle and gyro rate
// - result channel m_valid/m_ready returns axis_out, angle, unbiased rate, bias
// - one request is handled at a time; s_ready is high only while the sequencer
//   is idle
// - m_valid rises after a taken request has passed six prediction steps
//   through the shared registered multiplier, two 64-step restoring divisions,
//   each with its start step, six correction steps, then the store and output
//   steps
// - an axis of NUM_AXES or more is taken and dropped with no
//   result and no state change
// - the user writes configuration through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this
// - reset (aresetn low, synchronous) clears all filter state to zero and loads
//   the default time step and noise registers
// - when the receiver stalls the result is held in the output register; the
//   next request is still taken and its result waits in the output step
module angle_bias_kalman_filter_core #(
    parameter int NUM_AXES = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [29:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_axis,
    input  logic signed [31:0] s_measured_angle,
    input  logic signed [31:0] s_gyro_rate,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_axis_out,
    output logic signed [31:0] m_angle_estimate,
    output logic signed [31:0] m_unbiased_rate,
    output logic signed [31:0] m_bias_estimate
);
    localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    abkf_pkg::state_t state_reg, state_next;

    logic [29:0] dt_reg, qa_reg, qb_reg, r_reg;

    logic signed [31:0] ang_st [NUM_AXES];
    logic signed [31:0] bias_st [NUM_AXES];
    logic signed [31:0] c00_st [NUM_AXES];
    logic signed [31:0] c01_st [NUM_AXES];
    logic signed [31:0] c10_st [NUM_AXES];
    logic signed [31:0] c11_st [NUM_AXES];

    logic [AW-1:0] ax_reg;
    logic signed [31:0] z_reg, w_reg;
    logic signed [31:0] rate_reg, ang_reg, bias_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] k0_reg, k1_reg;
    logic signed [31:0] dtp11_reg;
    logic signed [34:0] t_reg;
    logic signed [32:0] y_reg;
    logic signed [31:0] b_old_reg, c00_reg, c01_reg, c10_reg, c11_reg, a_old_reg;

    logic        out_valid_reg;
    logic [1:0]  out_axis_reg;
    logic signed [31:0] out_ang_reg, out_rate_reg, out_bias_reg;
    logic        out_load;

    logic signed [32:0] mul_a;
    logic signed [34:0] mul_b;
    logic signed [66:0] mul_p;
    logic signed [31:0] mp32;

    abkf_pkg::div_ctrl_t div_ctl;
    logic signed [31:0] div_num;
    logic signed [31:0] div_q;
    logic signed [32:0] inno;

    logic accept;
    logic ax_ok;

    assign ax_ok  = (32'(s_axis) < 32'(NUM_AXES));
    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == abkf_pkg::ST_IDLE);
    assign out_load = (state_reg == abkf_pkg::ST_OUT) && (!out_valid_reg || m_ready);
    assign inno = 33'(p00_reg) + $signed({3'd0, r_reg});
    assign mp32 = abkf_pkg::sat32(mul_p);

    // multiplier operand select; the product is registered and used by the next step
    always_comb begin
        mul_a = 33'(signed'({3'd0, dt_reg}));
        mul_b = '0;
        unique case (state_reg)
            abkf_pkg::ST_LOAD:    mul_b = 35'(c11_reg);
            abkf_pkg::ST_M_RATE:  mul_b = 35'(rate_reg);
            abkf_pkg::ST_M_P11: begin
                mul_a = $signed({3'd0, qb_reg});
                mul_b = $signed({5'd0, dt_reg});
            end
            abkf_pkg::ST_M_T:     mul_b = t_reg;
            abkf_pkg::ST_M_K0Y: begin
                mul_a = 33'(k0_reg);
                mul_b = 35'(y_reg);
            end
            abkf_pkg::ST_M_K1Y: begin
                mul_a = 33'(k1_reg);
                mul_b = 35'(y_reg);
            end
            abkf_pkg::ST_M_K0P00: begin
                mul_a = 33'(k0_reg);
                mul_b = 35'(p00_reg);
            end
            abkf_pkg::ST_M_K0P01: begin
                mul_a = 33'(k0_reg);
                mul_b = 35'(p01_reg);
            end
            abkf_pkg::ST_M_K1P00: begin
                mul_a = 33'(k1_reg);
                mul_b = 35'(p00_reg);
            end
            abkf_pkg::ST_M_K1P01: begin
                mul_a = 33'(k1_reg);
                mul_b = 35'(p01_reg);
            end
            default: ;
        endcase
    end

    abkf_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    assign div_ctl.start = (state_reg == abkf_pkg::ST_DIV0_GO)
                        || (state_reg == abkf_pkg::ST_DIV1_GO);
    assign div_num = (state_reg == abkf_pkg::ST_DIV1_GO) ? p10_reg : p00_reg;

    abkf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_ctl.start),
        .num     (div_num),
        .den     (inno),
        .busy    (div_ctl.busy),
        .done    (div_ctl.done),
        .quot    (div_q)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            abkf_pkg::ST_IDLE:      if (accept && ax_ok) state_next = abkf_pkg::ST_LOAD;
            abkf_pkg::ST_LOAD:      state_next = abkf_pkg::ST_M_RATE;
            abkf_pkg::ST_M_RATE:    state_next = abkf_pkg::ST_M_P11;
            abkf_pkg::ST_M_P11:     state_next = abkf_pkg::ST_T_SUM;
            abkf_pkg::ST_T_SUM:     state_next = abkf_pkg::ST_M_T;
            abkf_pkg::ST_M_T:       state_next = abkf_pkg::ST_M_Q11;
            abkf_pkg::ST_M_Q11:     state_next = abkf_pkg::ST_DIV0_GO;
            abkf_pkg::ST_DIV0_GO:   state_next = abkf_pkg::ST_DIV0_WAIT;
            abkf_pkg::ST_DIV0_WAIT: if (div_ctl.done) state_next = abkf_pkg::ST_DIV1_GO;
            abkf_pkg::ST_DIV1_GO:   state_next = abkf_pkg::ST_DIV1_WAIT;
            abkf_pkg::ST_DIV1_WAIT: if (div_ctl.done) state_next = abkf_pkg::ST_M_K0Y;
            abkf_pkg::ST_M_K0Y:     state_next = abkf_pkg::ST_M_K1Y;
            abkf_pkg::ST_M_K1Y:     state_next = abkf_pkg::ST_M_K0P00;
            abkf_pkg::ST_M_K0P00:   state_next = abkf_pkg::ST_M_K0P01;
            abkf_pkg::ST_M_K0P01:   state_next = abkf_pkg::ST_M_K1P00;
            abkf_pkg::ST_M_K1P00:   state_next = abkf_pkg::ST_M_K1P01;
            abkf_pkg::ST_M_K1P01:   state_next = abkf_pkg::ST_STORE;
            abkf_pkg::ST_STORE:     state_next = abkf_pkg::ST_OUT;
            abkf_pkg::ST_OUT:       if (out_load) state_next = abkf_pkg::ST_IDLE;
            default:                state_next = abkf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= abkf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg <= 30'd10737418;
            qa_reg <= 30'd1073742;
            qb_reg <= 30'd3221225;
            r_reg  <= 30'd32212255;
        end else if (cfg_we) begin
            unique case (abkf_pkg::reg_idx_t'(cfg_index))
                abkf_pkg::REG_TIME_STEP:   dt_reg <= cfg_data;
                abkf_pkg::REG_ANGLE_NOISE: qa_reg <= cfg_data;
                abkf_pkg::REG_BIAS_NOISE:  qb_reg <= cfg_data;
                abkf_pkg::REG_MEAS_NOISE:  r_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // datapath: a step that uses a product captures the product of the previous step
    always_ff @(posedge aclk) begin
        case (state_reg)
            abkf_pkg::ST_IDLE: begin
                if (accept) begin
                    ax_reg <= AW'(s_axis);
                    z_reg  <= s_measured_angle;
                    w_reg  <= s_gyro_rate;
                    a_old_reg <= ang_st[AW'(s_axis)];
                    b_old_reg <= bias_st[AW'(s_axis)];
                    c00_reg <= c00_st[AW'(s_axis)];
                    c01_reg <= c01_st[AW'(s_axis)];
                    c10_reg <= c10_st[AW'(s_axis)];
                    c11_reg <= c11_st[AW'(s_axis)];
                end
            end
            abkf_pkg::ST_LOAD: begin
                rate_reg <= abkf_pkg::sat32(67'(w_reg) - 67'(b_old_reg));
            end
            abkf_pkg::ST_M_RATE: dtp11_reg <= mp32;
            abkf_pkg::ST_M_P11: begin
                ang_reg <= abkf_pkg::sat32(67'(a_old_reg) + mul_p);
            end
            abkf_pkg::ST_T_SUM: begin
                p01_reg <= abkf_pkg::sat32(67'(c01_reg) - 67'(dtp11_reg));
                p10_reg <= abkf_pkg::sat32(67'(c10_reg) - 67'(dtp11_reg));
                p11_reg <= abkf_pkg::sat32(67'(c11_reg) + mul_p);
                t_reg   <= 35'(dtp11_reg) - 35'(c01_reg) - 35'(c10_reg)
                         + $signed({5'd0, qa_reg});
            end
            abkf_pkg::ST_M_Q11: begin
                p00_reg <= abkf_pkg::sat32(67'(c00_reg) + mul_p);
            end
            abkf_pkg::ST_DIV0_WAIT: if (div_ctl.done) k0_reg <= div_q;
            abkf_pkg::ST_DIV1_WAIT: begin
                if (div_ctl.done) k1_reg <= div_q;
                y_reg <= 33'(z_reg) - 33'(ang_reg);
            end
            abkf_pkg::ST_M_K1Y: begin
                ang_reg <= abkf_pkg::sat32(67'(ang_reg) + mul_p);
            end
            abkf_pkg::ST_M_K0P00: begin
                bias_reg <= abkf_pkg::sat32(67'(b_old_reg) + mul_p);
            end
            abkf_pkg::ST_M_K0P01: c00_reg <= abkf_pkg::sat32(67'(p00_reg) - mul_p);
            abkf_pkg::ST_M_K1P00: c01_reg <= abkf_pkg::sat32(67'(p01_reg) - mul_p);
            abkf_pkg::ST_M_K1P01: c10_reg <= abkf_pkg::sat32(67'(p10_reg) - mul_p);
            abkf_pkg::ST_STORE:   c11_reg <= abkf_pkg::sat32(67'(p11_reg) - mul_p);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                ang_st[i]  <= '0;
                bias_st[i] <= '0;
                c00_st[i]  <= '0;
                c01_st[i]  <= '0;
                c10_st[i]  <= '0;
                c11_st[i]  <= '0;
            end
        end else if (out_load) begin
            ang_st[ax_reg]  <= ang_reg;
            bias_st[ax_reg] <= bias_reg;
            c00_st[ax_reg]  <= c00_reg;
            c01_st[ax_reg]  <= c01_reg;
            c10_st[ax_reg]  <= c10_reg;
            c11_st[ax_reg]  <= c11_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (out_load) begin
            out_axis_reg <= 2'(ax_reg);
            out_ang_reg  <= ang_reg;
            out_rate_reg <= rate_reg;
            out_bias_reg <= bias_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_axis_out       = out_axis_reg;
    assign m_angle_estimate = out_ang_reg;
    assign m_unbiased_rate  = out_rate_reg;
    assign m_bias_estimate  = out_bias_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != abkf_pkg::ST_IDLE) |-> !s_ready)
        else $error("request taken while busy");
    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_ctl.busy || div_ctl.done) |-> (state_reg == abkf_pkg::ST_DIV0_WAIT
                       || state_reg == abkf_pkg::ST_DIV1_WAIT))
        else $error("divider active outside a wait step");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_angle_estimate)))
        else $error("result dropped under stall");
`endif
endmodule

// ===== tb/angle_bias_kalman_filter_core_tb.sv =====
// testbench for the angle / bias kalman filter core: queued driver, checking monitor
`timescale 1ns / 1ps
module angle_bias_kalman_filter_core_tb;

    localparam int  AXES        = 3;
    localparam int  Q           = 30;
    localparam int  DRAIN_WAIT  = 400;
    localparam int  CYCLE_LIMIT = 4000000;
    localparam longint S32_MAX  = 64'sd2147483647;
    localparam longint S32_MIN  = -64'sd2147483648;

    typedef struct {
        logic [1:0]         axis;
        logic signed [31:0] angle;
        logic signed [31:0] rate;
    } sample_t;

    typedef struct {
        logic [1:0]         axis;
        logic signed [31:0] angle;
        logic signed [31:0] rate;
        logic signed [31:0] bias;
    } estimate_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = abkf_pkg::REG_TIME_STEP;
    logic [29:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_axis = '0;
    logic signed [31:0] s_measured_angle = '0;
    logic signed [31:0] s_gyro_rate = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_axis_out;
    logic signed [31:0] m_angle_estimate;
    logic signed [31:0] m_unbiased_rate;
    logic signed [31:0] m_bias_estimate;

    angle_bias_kalman_filter_core dut (.*);

    always #5 aclk = ~aclk;

    // filter copy kept in step with the block
    longint dt_r, qa_r, qb_r, rm_r;
    longint ang_m[AXES], bias_m[AXES], p00_m[AXES], p01_m[AXES], p10_m[AXES], p11_m[AXES];

    sample_t   pending_samples[$];
    estimate_t expected_estimates[$];
    int        error_count = 0;
    int        cycles = 0;

    function automatic longint clamp32(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint unsigned p, r;
        p = magnitude(a) * magnitude(b);
        r = (p + (64'd1 << (Q - 1))) >> Q;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint qdiv_gain(longint num, longint den);
        longint unsigned n, d, qt;
        if (den == 0) return 0;
        n  = magnitude(num) << Q;
        d  = magnitude(den);
        qt = (2 * n + d) / (2 * d);
        if (qt > (64'd1 << 32)) qt = 64'd1 << 32;
        return clamp32(((num < 0) != (den < 0)) ? -longint'(qt) : longint'(qt));
    endfunction

    task automatic filter_update(input sample_t s);
        estimate_t e;
        longint z, w, rate, ang, t, p00, p01, p10, p11, k0, k1, y, bias;
        int ax;
        ax = s.axis;
        if (ax >= AXES) return;
        z    = s.angle;
        w    = s.rate;
        rate = clamp32(w - bias_m[ax]);
        ang  = clamp32(ang_m[ax] + qmul(dt_r, rate));
        p11  = p11_m[ax];
        t    = qmul(dt_r, p11) - p01_m[ax] - p10_m[ax] + qa_r;
        p00  = clamp32(p00_m[ax] + qmul(dt_r, t));
        p01  = clamp32(p01_m[ax] - qmul(dt_r, p11));
        p10  = clamp32(p10_m[ax] - qmul(dt_r, p11));
        p11  = clamp32(p11 + qmul(qb_r, dt_r));
        k0   = qdiv_gain(p00, p00 + rm_r);
        k1   = qdiv_gain(p10, p00 + rm_r);
        y    = z - ang;
        ang  = clamp32(ang + qmul(k0, y));
        bias = clamp32(bias_m[ax] + qmul(k1, y));
        ang_m[ax]  = ang;
        bias_m[ax] = bias;
        p00_m[ax]  = clamp32(p00 - qmul(k0, p00));
        p01_m[ax]  = clamp32(p01 - qmul(k0, p01));
        p10_m[ax]  = clamp32(p10 - qmul(k1, p00));
        p11_m[ax]  = clamp32(p11 - qmul(k1, p01));
        e.axis  = s.axis;
        e.angle = ang[31:0];
        e.rate  = rate[31:0];
        e.bias  = bias[31:0];
        expected_estimates.push_back(e);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // sender: bursts with gaps
    int burst_left = 1, gap_left = 0;
    always @(posedge aclk) begin
        sample_t s;
        logic    load;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                s.axis  = s_axis;
                s.angle = s_measured_angle;
                s.rate  = s_gyro_rate;
                filter_update(s);
            end
            load = 1'b0;
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_samples.size() > 0) begin
                    load = 1'b1;
                    s = pending_samples.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 8);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
                s_valid <= load;
                if (load) begin
                    s_axis           <= s.axis;
                    s_measured_angle <= s.angle;
                    s_gyro_rate      <= s.rate;
                end
            end
        end
    end

    // receiver: stall pattern chosen at random from three modes
    int stall_mode = 0;
    always @(posedge aclk) begin
        estimate_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("angle_bias_kalman_filter_core_tb: errors");
            $finish;
        end
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_estimates.size() == 0) begin
                    report_mismatch("unexpected request, axis", m_axis_out, -1);
                end else begin
                    e = expected_estimates.pop_front();
                    if (m_axis_out !== e.axis) report_mismatch("axis_out", m_axis_out, e.axis);
                    if (m_angle_estimate !== e.angle)
                        report_mismatch("angle_estimate", m_angle_estimate, e.angle);
                    if (m_unbiased_rate !== e.rate)
                        report_mismatch("unbiased_rate", m_unbiased_rate, e.rate);
                    if (m_bias_estimate !== e.bias)
                        report_mismatch("bias_estimate", m_bias_estimate, e.bias);
                end
            end
            if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic write_reg(input abkf_pkg::reg_idx_t idx, input logic [29:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            abkf_pkg::REG_TIME_STEP:   dt_r = val;
            abkf_pkg::REG_ANGLE_NOISE: qa_r = val;
            abkf_pkg::REG_BIAS_NOISE:  qb_r = val;
            default:                   rm_r = val;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // settle, then look again in case a request was still on its way in
    task automatic drain();
        do begin
            wait (pending_samples.size() == 0 && !s_valid && expected_estimates.size() == 0);
            repeat (DRAIN_WAIT) @(posedge aclk);
        end while (!(pending_samples.size() == 0 && !s_valid
                     && expected_estimates.size() == 0));
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            3: return $signed($urandom_range(0, 2 * 5898240)) - 32'sd5898240; // +-90 deg
            4: return $signed($urandom_range(0, 4096)) - 32'sd2048;
            default: return $signed($urandom_range(0, 2 * 23592960)) - 32'sd23592960;
        endcase
    endfunction

    task automatic queue_sample(input logic [1:0] ax, input logic signed [31:0] a,
                                input logic signed [31:0] r);
        sample_t s;
        s.axis  = ax;
        s.angle = a;
        s.rate  = r;
        pending_samples.push_back(s);
    endtask

    task automatic queue_random(input int n);
        logic [1:0] ax;
        for (int i = 0; i < n; i++) begin
            ax = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, AXES - 1));
            queue_sample(ax, pick_value(), pick_value());
        end
    endtask

    initial begin
        dt_r = 10737418; qa_r = 1073742; qb_r = 3221225; rm_r = 32212255;
        for (int i = 0; i < AXES; i++) begin
            ang_m[i] = 0; bias_m[i] = 0;
            p00_m[i] = 0; p01_m[i] = 0; p10_m[i] = 0; p11_m[i] = 0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // zero innovation variance: all noises zero on a fresh covariance
        write_reg(abkf_pkg::REG_ANGLE_NOISE, 30'd0);
        write_reg(abkf_pkg::REG_BIAS_NOISE, 30'd0);
        write_reg(abkf_pkg::REG_MEAS_NOISE, 30'd0);
        queue_sample(2'd0, 32'sh00010000, 32'sh00020000);
        queue_sample(2'd0, 32'sh80000000, 32'sh7fffffff);
        drain();

        // defaults back, directed extremes on every axis, dropped axis
        write_reg(abkf_pkg::REG_ANGLE_NOISE, 30'd1073742);
        write_reg(abkf_pkg::REG_BIAS_NOISE, 30'd3221225);
        write_reg(abkf_pkg::REG_MEAS_NOISE, 30'd32212255);
        queue_sample(2'd1, 32'sh7fffffff, 32'sh7fffffff);
        queue_sample(2'd1, 32'sh80000000, 32'sh80000000);
        queue_sample(2'd2, 32'sh00000000, 32'shffffffff);
        queue_sample(2'd3, 32'sh12345678, 32'sh7654321);
        queue_sample(2'd2, 32'shffffffff, 32'sh00000001);
        queue_sample(2'd0, 32'sh7fffffff, 32'sh80000000);
        queue_sample(2'd3, 32'shffffffff, 32'shffffffff);
        queue_sample(2'd1, 32'sh00000000, 32'sh00000000);
        queue_random(300);
        drain();

        // extremes of every register
        write_reg(abkf_pkg::REG_TIME_STEP, 30'h3fffffff);
        write_reg(abkf_pkg::REG_ANGLE_NOISE, 30'h3fffffff);
        write_reg(abkf_pkg::REG_BIAS_NOISE, 30'h3fffffff);
        write_reg(abkf_pkg::REG_MEAS_NOISE, 30'd1);
        queue_random(250);
        drain();

        write_reg(abkf_pkg::REG_TIME_STEP, 30'd1);
        write_reg(abkf_pkg::REG_ANGLE_NOISE, 30'd0);
        write_reg(abkf_pkg::REG_BIAS_NOISE, 30'd0);
        write_reg(abkf_pkg::REG_MEAS_NOISE, 30'h3fffffff);
        queue_random(250);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            write_reg(abkf_pkg::REG_TIME_STEP, 30'($urandom_range(1, 32'h3fffffff)));
            write_reg(abkf_pkg::REG_ANGLE_NOISE, 30'($urandom));
            write_reg(abkf_pkg::REG_BIAS_NOISE, 30'($urandom));
            write_reg(abkf_pkg::REG_MEAS_NOISE, 30'($urandom_range(1, 32'h3fffffff)));
            queue_random(220);
            drain();
        end

        if (error_count == 0) begin
            $display("angle_bias_kalman_filter_core_tb: clean");
        end else begin
            $display("angle_bias_kalman_filter_core_tb: errors");
        end
        $finish;
    end

endmodule
